// File: design/nstg_pkg.sv
// ----------------------------------------------------------------------------
// nstg_pkg
// Shared types and constants of the synthetic traffic generator.
// ----------------------------------------------------------------------------
`default_nettype none

package nstg_pkg;

  localparam int unsigned ADDR_SHIFT     = 6;
  localparam int unsigned MAX_RADIX_LOG2 = 4;

  localparam int unsigned NODE_W    = 8;
  localparam int unsigned RADIX_W   = 3;
  localparam int unsigned PATTERN_W = 4;
  localparam int unsigned SEL_W     = 9;
  localparam int unsigned THRESH_W  = 17;
  localparam int unsigned LIMIT_W   = 32;
  localparam int unsigned VNET_W    = 2;
  localparam int unsigned DRAW_W    = 16;
  localparam int unsigned ADDR_W    = 14;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned COUNT_W   = 32;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 24;

  // Register indexes (word address bits of paddr).
  localparam logic [2:0] REG_NODE_ID       = 3'd0;
  localparam logic [2:0] REG_RADIX_LOG2    = 3'd1;
  localparam logic [2:0] REG_PATTERN       = 3'd2;
  localparam logic [2:0] REG_FIXED_DEST    = 3'd3;
  localparam logic [2:0] REG_SENDER_SELECT = 3'd4;
  localparam logic [2:0] REG_INJECT_THRESH = 3'd5;
  localparam logic [2:0] REG_PACKET_LIMIT  = 3'd6;
  localparam logic [2:0] REG_VNET_SELECT   = 3'd7;

  // Traffic pattern codes.
  localparam logic [PATTERN_W-1:0] PAT_UNIFORM    = 4'd0;
  localparam logic [PATTERN_W-1:0] PAT_COMPLEMENT = 4'd1;
  localparam logic [PATTERN_W-1:0] PAT_REVERSE    = 4'd2;
  localparam logic [PATTERN_W-1:0] PAT_ROTATION   = 4'd3;
  localparam logic [PATTERN_W-1:0] PAT_NEIGHBOR   = 4'd4;
  localparam logic [PATTERN_W-1:0] PAT_SHUFFLE    = 4'd5;
  localparam logic [PATTERN_W-1:0] PAT_TRANSPOSE  = 4'd6;
  localparam logic [PATTERN_W-1:0] PAT_TORNADO    = 4'd7;
  localparam logic [PATTERN_W-1:0] PAT_HOTSPOT    = 4'd8;
  localparam logic [PATTERN_W-1:0] PAT_CUSTOM     = 4'd9;

  // Request kinds, one per virtual network.
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IFETCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd2;
  localparam logic [VNET_W-1:0] VNET_RANDOM = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0]    node_id;
    logic [RADIX_W-1:0]   radix_log2;
    logic [PATTERN_W-1:0] pattern;
    logic [SEL_W-1:0]     fixed_dest;
  } nstg_dest_cfg_t;

endpackage

`default_nettype wire

// File: design/nstg_dest_calc.sv
// ----------------------------------------------------------------------------
// nstg_dest_calc
// Destination selection for one packet from the configured traffic pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module nstg_dest_calc
  import nstg_pkg::*;
(
  input  wire nstg_dest_cfg_t    cfg_i,
  input  wire logic [NODE_W-1:0] rand_dest_i,
  input  wire logic              rand_hot_i,
  output logic [NODE_W-1:0]      dest_o,
  output logic                   dest_ok_o
);

  logic [RADIX_W-1:0] r;
  logic [3:0]         r2;
  logic [NODE_W:0]    n_full;
  logic [NODE_W-1:0]  n_mask;
  logic [NODE_W-1:0]  half_n;
  logic [NODE_W-1:0]  side_full;
  logic [NODE_W-1:0]  side_mask;
  logic [NODE_W-1:0]  ca;
  logic [NODE_W-1:0]  ctr;
  logic [NODE_W-1:0]  src;
  logic [NODE_W-1:0]  sx;
  logic [NODE_W-1:0]  sy;
  logic [NODE_W-1:0]  rev8;
  logic [NODE_W-1:0]  uniform;

  always_comb begin
    priority if (cfg_i.radix_log2 < RADIX_W'(1)) begin
      r = RADIX_W'(1);
    end else if (cfg_i.radix_log2 > RADIX_W'(MAX_RADIX_LOG2)) begin
      r = RADIX_W'(MAX_RADIX_LOG2);
    end else begin
      r = cfg_i.radix_log2;
    end
  end

  assign r2        = {1'b0, r} << 1;
  assign n_full    = (NODE_W+1)'(1) << r2;
  assign n_mask    = n_full[NODE_W-1:0] - NODE_W'(1);
  assign half_n    = n_full[NODE_W:1];
  assign side_full = NODE_W'(1) << r;
  assign side_mask = side_full - NODE_W'(1);
  assign ca        = {1'b0, side_full[NODE_W-1:1]};
  assign ctr       = (ca << r) | ca;
  assign src       = cfg_i.node_id & n_mask;
  assign sx        = src & side_mask;
  assign sy        = src >> r;
  assign uniform   = rand_dest_i & n_mask;

  always_comb begin
    for (int i = 0; i < NODE_W; i++) begin
      rev8[i] = src[NODE_W-1-i];
    end
  end

  always_comb begin
    dest_ok_o = 1'b1;
    dest_o    = '0;
    if (!cfg_i.fixed_dest[SEL_W-1]) begin
      dest_o = cfg_i.fixed_dest[NODE_W-1:0];
    end else begin
      unique case (cfg_i.pattern)
        PAT_UNIFORM:    dest_o = uniform;
        PAT_COMPLEMENT: dest_o = ~src & n_mask;
        PAT_REVERSE:    dest_o = rev8 >> (4'd8 - r2);
        PAT_ROTATION:   dest_o = (src >> 1) | ({7'd0, src[0]} << (r2 - 4'd1));
        PAT_NEIGHBOR:   dest_o = (src & ~side_mask) | ((sx + NODE_W'(1)) & side_mask);
        PAT_SHUFFLE:    dest_o = ((src << 1) | (src >> (r2 - 4'd1))) & n_mask;
        PAT_TRANSPOSE:  dest_o = (sx << r) | sy;
        PAT_TORNADO: begin
          dest_o = (src & ~side_mask) | ((sx + ca - NODE_W'(1)) & side_mask);
        end
        PAT_HOTSPOT:    dest_o = half_n - NODE_W'(1) + {7'd0, rand_hot_i};
        PAT_CUSTOM: begin
          if (src == ctr) begin
            dest_o = ctr - NODE_W'(1);
          end else if (src == ctr - NODE_W'(1)) begin
            dest_o = ctr;
          end else begin
            dest_o = uniform;
          end
        end
        default: dest_ok_o = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/noc_synthetic_traffic_generator.sv
// ----------------------------------------------------------------------------
// noc_synthetic_traffic_generator
// Synthetic packet source for one node of a square mesh network-on-chip.
// ----------------------------------------------------------------------------
// Each input item is one clock tick of random draws. The generator takes one
// item every clock cycle unless the output stalls, and returns at most one
// packet descriptor for it via the input and output registers, with the inject
// decision, destination pattern and send counter update done in a single
// combinational pass between them. Ticks that inject nothing produce no output
// item. The user must write configuration over the APB port while the stream is
// idle; the block does not enforce this. No initialization pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module noc_synthetic_traffic_generator
  import nstg_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // APB configuration port.
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]     pwdata,
  output logic      [PDATA_W-1:0]     prdata,
  output logic                        pready,
  // Input stream.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: rand_inject[15:0], rand_dest[23:16], rand_hot[24], rand_vnet[26:25].
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Output stream.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata: destination[7:0], address[21:8].
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: request_kind[1:0].
  output logic      [KIND_W-1:0]      m_axis_tuser
);

  logic [NODE_W-1:0]    node_id_q;
  logic [RADIX_W-1:0]   radix_log2_q;
  logic [PATTERN_W-1:0] pattern_q;
  logic [SEL_W-1:0]     fixed_dest_q;
  logic [SEL_W-1:0]     sender_select_q;
  logic [THRESH_W-1:0]  inject_threshold_q;
  logic [LIMIT_W-1:0]   packet_limit_q;
  logic [VNET_W-1:0]    vnet_select_q;
  logic [COUNT_W-1:0]   sent_count_q, sent_count_d;

  logic                 cfg_write;
  logic [2:0]           cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q          <= '0;
      radix_log2_q       <= RADIX_W'(2);
      pattern_q          <= PAT_UNIFORM;
      fixed_dest_q       <= '1;
      sender_select_q    <= '1;
      inject_threshold_q <= '0;
      packet_limit_q     <= '1;
      vnet_select_q      <= VNET_RANDOM;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NODE_ID:       node_id_q          <= pwdata[NODE_W-1:0];
        REG_RADIX_LOG2:    radix_log2_q       <= pwdata[RADIX_W-1:0];
        REG_PATTERN:       pattern_q          <= pwdata[PATTERN_W-1:0];
        REG_FIXED_DEST:    fixed_dest_q       <= pwdata[SEL_W-1:0];
        REG_SENDER_SELECT: sender_select_q    <= pwdata[SEL_W-1:0];
        REG_INJECT_THRESH: inject_threshold_q <= pwdata[THRESH_W-1:0];
        REG_PACKET_LIMIT:  packet_limit_q     <= pwdata[LIMIT_W-1:0];
        REG_VNET_SELECT:   vnet_select_q      <= pwdata[VNET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_NODE_ID:       prdata = PDATA_W'(node_id_q);
      REG_RADIX_LOG2:    prdata = PDATA_W'(radix_log2_q);
      REG_PATTERN:       prdata = PDATA_W'(pattern_q);
      REG_FIXED_DEST:    prdata = PDATA_W'(fixed_dest_q);
      REG_SENDER_SELECT: prdata = PDATA_W'(sender_select_q);
      REG_INJECT_THRESH: prdata = PDATA_W'(inject_threshold_q);
      REG_PACKET_LIMIT:  prdata = packet_limit_q;
      REG_VNET_SELECT:   prdata = PDATA_W'(vnet_select_q);
      default:           prdata = '0;
    endcase
  end

  // Input register.
  logic                 in_valid_q;
  logic [DRAW_W-1:0]    rand_inject_q;
  logic [NODE_W-1:0]    rand_dest_q;
  logic                 rand_hot_q;
  logic [VNET_W-1:0]    rand_vnet_q;

  // Output register.
  logic                 out_valid_q;
  logic [NODE_W-1:0]    dest_q;
  logic [ADDR_W-1:0]    address_q;
  logic [KIND_W-1:0]    kind_q;

  nstg_dest_cfg_t       dest_cfg;
  logic [NODE_W-1:0]    dest;
  logic                 dest_ok;
  logic                 draw_ok;
  logic                 limit_ok;
  logic                 sender_ok;
  logic                 inject;
  logic                 out_free;
  logic                 in_done;
  logic                 load_out;
  logic [KIND_W-1:0]    kind;

  assign dest_cfg.node_id    = node_id_q;
  assign dest_cfg.radix_log2 = radix_log2_q;
  assign dest_cfg.pattern    = pattern_q;
  assign dest_cfg.fixed_dest = fixed_dest_q;

  nstg_dest_calc u_dest_calc (
    .cfg_i       (dest_cfg),
    .rand_dest_i (rand_dest_q),
    .rand_hot_i  (rand_hot_q),
    .dest_o      (dest),
    .dest_ok_o   (dest_ok)
  );

  assign draw_ok   = {1'b0, rand_inject_q} < inject_threshold_q;
  assign limit_ok  = packet_limit_q[LIMIT_W-1] || (sent_count_q < packet_limit_q);
  assign sender_ok = sender_select_q[SEL_W-1] ||
                     ({1'b0, node_id_q} == sender_select_q);
  assign inject    = draw_ok && limit_ok && sender_ok && dest_ok;

  always_comb begin
    if (vnet_select_q == VNET_RANDOM) begin
      kind = (rand_vnet_q == VNET_RANDOM) ? KIND_WRITE : rand_vnet_q;
    end else begin
      kind = vnet_select_q;
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_done       = in_valid_q && (!inject || out_free);
  assign load_out      = in_valid_q && inject && out_free;
  assign s_axis_tready = !in_valid_q || in_done;
  assign sent_count_d  = sent_count_q + COUNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      sent_count_q <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= load_out;
      end
      if (load_out) begin
        sent_count_q <= sent_count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      rand_inject_q <= s_axis_tdata[15:0];
      rand_dest_q   <= s_axis_tdata[23:16];
      rand_hot_q    <= s_axis_tdata[24];
      rand_vnet_q   <= s_axis_tdata[26:25];
    end
    if (load_out) begin
      dest_q    <= dest;
      address_q <= ADDR_W'(dest) << ADDR_SHIFT;
      kind_q    <= kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, address_q, dest_q};
  assign m_axis_tuser  = kind_q;

endmodule

`default_nettype wire
